FILE: design/dlr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pkg
// Types, constants and helpers shared by the line rasterizer modules.
// ----------------------------------------------------------------------------
package dlr_pkg;

	localparam int COORD_W    = 16;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_WIDTH  = 2048;

	localparam int MAG_W      = COORD_W + 1;             // signed delta / magnitude
	localparam int SLOPE_W    = FRAC_BITS + 2;           // signed slope, |q| <= 1.0
	localparam int ACC_W      = COORD_W + FRAC_BITS + 2; // signed accumulator
	localparam int CALC_W     = ACC_W - FRAC_BITS;       // pixel coordinate math
	localparam int PIX_W      = 17;
	localparam int CFG_W      = 12;
	localparam int COLOR_W    = 8;
	localparam int ADDR_W     = 24;
	localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
	localparam int LIN_W      = 2 * DIM_W + 1;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int IDX_W      = 3;

	localparam int IN_TDATA_W    = 4 * COORD_W;
	localparam int OUT_FIELDS_W  = 2 * PIX_W + ADDR_W + 3 * COLOR_W;
	localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CFG_W-1:0]   RST_FRAME_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0]   RST_FRAME_HEIGHT = CFG_W'(480);
	localparam logic [COLOR_W-1:0] RST_RED          = COLOR_W'(255);
	localparam logic [COLOR_W-1:0] RST_GREEN        = COLOR_W'(0);
	localparam logic [COLOR_W-1:0] RST_BLUE         = COLOR_W'(0);

	typedef enum logic [0:0] {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_type_t;

	typedef enum logic [IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_DRAW_RED     = 3'd2,
		REG_DRAW_GREEN   = 3'd3,
		REG_DRAW_BLUE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic load;       // latch a new line from the input word
		logic div_step;   // one restoring division step
		logic div_finish; // write signed slope, arm the line
		logic pix_step;   // emit one pixel and advance
	} ctrl_cmd_t;

	typedef struct packed {
		logic zero_len;
		logic line_active;
	} dp_status_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic                    outside;
		logic                    last;
	} pix_t;

	// frame dimensions saturate at the largest supported width
	function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (32'(v) > MAX_WIDTH) begin
			r = DIM_W'(MAX_WIDTH);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/dda_line_rasterizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer emitting pixel coordinates and packed 24-bit addresses.
// ----------------------------------------------------------------------------
// A start word (tuser 0) loads a line and computes its minor-axis slope with
// a one-bit-per-cycle restoring divider: the block takes the start word, runs
// the divide steps, then signs the slope, and holds the input off until it is
// done (a zero-length line skips the division). Step words (tuser 1) go at one
// per cycle while the address pipeline is ready; each emits one pixel through a
// three-register address pipeline (pixel, row multiply-add, times three).
// Steps with no line armed are taken and produce nothing. tlast marks the
// final pixel and tuser flags pixels outside the frame, whose address reads
// zero. Configuration takes effect on the next word and must only be written
// while no pixel is pending.
module dda_line_rasterizer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48]
	input  wire logic [dlr_pkg::IN_TDATA_W-1:0]       s_tdata,
	// req_type [0]
	input  wire logic [0:0]                           s_tuser,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// pixel_x [16:0], pixel_y [33:17], byte_addr [57:34], blue_byte [65:58],
	// green_byte [73:66], red_byte [81:74], zero [87:82]
	output logic [dlr_pkg::OUT_TDATA_W-1:0]           m_tdata,
	// off_frame [0]
	output logic [0:0]                                m_tuser,
	output logic                                      m_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic                                 cfg_wen,
	input  wire logic [dlr_pkg::IDX_W-1:0]            cfg_addr,
	input  wire logic [dlr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int COORD_W = dlr_pkg::COORD_W;

	logic [dlr_pkg::CFG_W-1:0]   frame_width_q, frame_height_q;
	logic [dlr_pkg::COLOR_W-1:0] draw_red_q, draw_green_q, draw_blue_q;
	logic [dlr_pkg::DIM_W-1:0]   frame_w, frame_h;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= dlr_pkg::RST_FRAME_WIDTH;
			frame_height_q <= dlr_pkg::RST_FRAME_HEIGHT;
			draw_red_q     <= dlr_pkg::RST_RED;
			draw_green_q   <= dlr_pkg::RST_GREEN;
			draw_blue_q    <= dlr_pkg::RST_BLUE;
		end else if (cfg_wen) begin
			unique case (dlr_pkg::cfg_reg_t'(cfg_addr))
				dlr_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				dlr_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				dlr_pkg::REG_DRAW_RED:     draw_red_q     <= cfg_data[dlr_pkg::COLOR_W-1:0];
				dlr_pkg::REG_DRAW_GREEN:   draw_green_q   <= cfg_data[dlr_pkg::COLOR_W-1:0];
				dlr_pkg::REG_DRAW_BLUE:    draw_blue_q    <= cfg_data[dlr_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	assign frame_w = dlr_pkg::sat_dim(frame_width_q);
	assign frame_h = dlr_pkg::sat_dim(frame_height_q);

	dlr_pkg::ctrl_cmd_t  cmd;
	dlr_pkg::dp_status_t status;
	dlr_pkg::pix_t       pix;
	logic                pipe_ready;

	logic signed [dlr_pkg::PIX_W-1:0] out_px, out_py;
	logic [dlr_pkg::ADDR_W-1:0]       out_addr;
	logic                             out_outside, out_last;

	dlr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.req_type   (s_tuser),
		.pipe_ready (pipe_ready),
		.status     (status),
		.cmd        (cmd)
	);

	dlr_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.start_x (s_tdata[COORD_W-1:0]),
		.start_y (s_tdata[2*COORD_W-1:COORD_W]),
		.end_x   (s_tdata[3*COORD_W-1:2*COORD_W]),
		.end_y   (s_tdata[4*COORD_W-1:3*COORD_W]),
		.frame_w (frame_w),
		.frame_h (frame_h),
		.status  (status),
		.pix     (pix)
	);

	dlr_pixel_pipe u_pixel_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd.pix_step),
		.pix         (pix),
		.frame_w     (frame_w),
		.in_ready    (pipe_ready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_px      (out_px),
		.out_py      (out_py),
		.out_addr    (out_addr),
		.out_outside (out_outside),
		.out_last    (out_last)
	);

	assign m_tdata = dlr_pkg::OUT_TDATA_W'({draw_red_q, draw_green_q, draw_blue_q,
		out_addr, out_py, out_px});
	assign m_tuser = out_outside;
	assign m_tlast = out_last;

endmodule
`default_nettype wire

FILE: design/dlr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_ctrl
// Sequencer: accepts words, runs the slope division, issues pixel steps.
// ----------------------------------------------------------------------------
module dlr_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [0:0]             req_type,
	input  wire logic                   pipe_ready,
	input  wire dlr_pkg::dp_status_t    status,
	output dlr_pkg::ctrl_cmd_t          cmd
);

	dlr_pkg::ctrl_state_t state_q, state_d;
	logic [dlr_pkg::CNT_W-1:0] count_q;
	logic fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlr_pkg::ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dlr_pkg::ST_DIVIDE) begin
				count_q <= count_q + 1'b1;
			end else begin
				count_q <= '0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		fire     = 1'b0;
		cmd      = '0;
		unique case (state_q)
			dlr_pkg::ST_IDLE: begin
				s_tready = pipe_ready;
				fire     = s_tvalid && pipe_ready;
				if (fire && (dlr_pkg::req_type_t'(req_type) == dlr_pkg::REQ_START)) begin
					cmd.load = 1'b1;
					if (!status.zero_len) begin
						state_d = dlr_pkg::ST_DIVIDE;
					end
				end else if (fire && status.line_active) begin
					cmd.pix_step = 1'b1;
				end
			end
			dlr_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (count_q == dlr_pkg::CNT_W'(dlr_pkg::DIV_STEPS - 1)) begin
					state_d = dlr_pkg::ST_FINISH;
				end
			end
			dlr_pkg::ST_FINISH: begin
				cmd.div_finish = 1'b1;
				state_d        = dlr_pkg::ST_IDLE;
			end
			default: begin
				state_d = dlr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/dlr_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_datapath
// Line state, restoring slope divider and per-step pixel coordinates.
// ----------------------------------------------------------------------------
module dlr_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire dlr_pkg::ctrl_cmd_t                   cmd,
	input  wire logic signed [dlr_pkg::COORD_W-1:0]   start_x,
	input  wire logic signed [dlr_pkg::COORD_W-1:0]   start_y,
	input  wire logic signed [dlr_pkg::COORD_W-1:0]   end_x,
	input  wire logic signed [dlr_pkg::COORD_W-1:0]   end_y,
	input  wire logic [dlr_pkg::DIM_W-1:0]            frame_w,
	input  wire logic [dlr_pkg::DIM_W-1:0]            frame_h,
	output dlr_pkg::dp_status_t                       status,
	output dlr_pkg::pix_t                             pix
);

	localparam int MAG_W   = dlr_pkg::MAG_W;
	localparam int F       = dlr_pkg::FRAC_BITS;
	localparam int SLOPE_W = dlr_pkg::SLOPE_W;
	localparam int ACC_W   = dlr_pkg::ACC_W;
	localparam int CALC_W  = dlr_pkg::CALC_W;
	localparam int COORD_W = dlr_pkg::COORD_W;

	// line state
	logic                        line_active_q;
	logic                        y_major_q;
	logic                        step_neg_q;
	logic signed [COORD_W-1:0]   origin_x_q, origin_y_q;
	logic signed [MAG_W-1:0]     major_index_q, major_end_q;
	logic signed [SLOPE_W-1:0]   minor_slope_q;
	logic signed [ACC_W-1:0]     minor_accum_q;

	// divider
	logic [MAG_W-1:0] alon_q, rem_q;
	logic [F:0]       dvd_q, quo_q;
	logic             sho_neg_q;

	// start decode
	logic signed [MAG_W-1:0] dx, dy, lon;
	logic [MAG_W-1:0]        adx, ady, alon, asho;
	logic                    ymaj;

	assign dx  = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
	assign dy  = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
	assign adx = dx[MAG_W-1] ? MAG_W'(~dx + 1'b1) : MAG_W'(dx);
	assign ady = dy[MAG_W-1] ? MAG_W'(~dy + 1'b1) : MAG_W'(dy);
	// |dy| > |dx| is the same test as dy*dy > dx*dx; ties stay on x
	assign ymaj = ady > adx;
	assign lon  = ymaj ? dy : dx;
	assign alon = ymaj ? ady : adx;
	assign asho = ymaj ? adx : ady;

	assign status.zero_len    = (alon == '0);
	assign status.line_active = line_active_q;

	// remainder stays below alon, so the top quotient bits above F are zero
	logic [MAG_W:0]   shifted, diff;
	logic             ge;
	logic [MAG_W-1:0] rem_next;

	assign shifted  = {rem_q, dvd_q[F]};
	assign diff     = shifted - {1'b0, alon_q};
	assign ge       = shifted >= {1'b0, alon_q};
	assign rem_next = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];

	logic signed [SLOPE_W-1:0] q_ext;
	assign q_ext = {1'b0, quo_q};

	// pixel for the current index
	logic signed [ACC_W-1:0]  acc_bias, off_full;
	logic signed [CALC_W-1:0] off, idx_ext, px_c, py_c;
	logic signed [MAG_W-1:0]  next_idx;
	logic                     last;

	// truncate toward zero: bias negatives before the arithmetic shift
	assign acc_bias = minor_accum_q +
		(minor_accum_q[ACC_W-1] ? ACC_W'((1 << F) - 1) : ACC_W'(0));
	assign off_full = acc_bias >>> F;
	assign off      = off_full[CALC_W-1:0];
	assign idx_ext  = CALC_W'(major_index_q);

	assign px_c = CALC_W'(origin_x_q) + (y_major_q ? off : idx_ext);
	assign py_c = CALC_W'(origin_y_q) + (y_major_q ? idx_ext : off);

	assign next_idx = step_neg_q ? major_index_q - 1'b1 : major_index_q + 1'b1;
	assign last     = (next_idx == major_end_q);

	assign pix.px      = px_c[dlr_pkg::PIX_W-1:0];
	assign pix.py      = py_c[dlr_pkg::PIX_W-1:0];
	assign pix.last    = last;
	assign pix.outside = px_c[CALC_W-1] || py_c[CALC_W-1] ||
		($unsigned(px_c) >= CALC_W'(frame_w)) ||
		($unsigned(py_c) >= CALC_W'(frame_h));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_active_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				line_active_q <= 1'b0;
			end else if (cmd.div_finish) begin
				line_active_q <= 1'b1;
			end else if (cmd.pix_step && last) begin
				line_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			origin_x_q    <= start_x;
			origin_y_q    <= start_y;
			y_major_q     <= ymaj;
			major_end_q   <= lon;
			major_index_q <= '0;
			step_neg_q    <= lon[MAG_W-1];
			minor_accum_q <= '0;
			sho_neg_q     <= ymaj ? dx[MAG_W-1] : dy[MAG_W-1];
			alon_q        <= alon;
			rem_q         <= asho >> 1;
			dvd_q         <= {asho[0], F'(0)};
		end
		if (cmd.div_step) begin
			rem_q <= rem_next;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[F-1:0], ge};
		end
		if (cmd.div_finish) begin
			minor_slope_q <= sho_neg_q ? -q_ext : q_ext;
		end
		if (cmd.pix_step) begin
			major_index_q <= next_idx;
			minor_accum_q <= minor_accum_q +
				{{(ACC_W-SLOPE_W){minor_slope_q[SLOPE_W-1]}}, minor_slope_q};
		end
	end

endmodule
`default_nettype wire

FILE: design/dlr_pixel_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlr_pixel_pipe
// Address pipeline: register pixel, row multiply-add, times three, output.
// ----------------------------------------------------------------------------
module dlr_pixel_pipe (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire dlr_pkg::pix_t                       pix,
	input  wire logic [dlr_pkg::DIM_W-1:0]           frame_w,
	output logic                                     in_ready,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [dlr_pkg::PIX_W-1:0]         out_px,
	output logic signed [dlr_pkg::PIX_W-1:0]         out_py,
	output logic [dlr_pkg::ADDR_W-1:0]               out_addr,
	output logic                                     out_outside,
	output logic                                     out_last
);

	localparam int DIM_W = dlr_pkg::DIM_W;
	localparam int LIN_W = dlr_pkg::LIN_W;

	logic                 v_s1, v_s2, v_s3;
	logic                 rdy_s1, rdy_s2, rdy_s3;
	dlr_pkg::pix_t        pix_s1;
	dlr_pkg::pix_t        pix_s2;
	logic [LIN_W-1:0]     lin_s2;
	logic [LIN_W:0]       tri_s2;
	dlr_pkg::pix_t        pix_s3;
	logic [dlr_pkg::ADDR_W-1:0] addr_s3;

	assign rdy_s3   = !v_s3 || out_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign tri_s2 = {lin_s2, 1'b0} + {1'b0, lin_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			pix_s1 <= pix;
		end
		if (rdy_s2) begin
			pix_s2 <= pix_s1;
			// only meaningful in frame, where both coordinates fit DIM_W bits
			lin_s2 <= LIN_W'(frame_w) * LIN_W'(pix_s1.py[DIM_W-1:0]) +
				LIN_W'(pix_s1.px[DIM_W-1:0]);
		end
		if (rdy_s3) begin
			pix_s3  <= pix_s2;
			addr_s3 <= pix_s2.outside ? '0 : dlr_pkg::ADDR_W'(tri_s2);
		end
	end

	assign out_valid   = v_s3;
	assign out_px      = pix_s3.px;
	assign out_py      = pix_s3.py;
	assign out_addr    = addr_s3;
	assign out_outside = pix_s3.outside;
	assign out_last    = pix_s3.last;

endmodule
`default_nettype wire

FILE: sim/dda_line_rasterizer_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer_tb
// Stream testbench for the DDA line rasterizer: directed lines, then random
// lines under several frame and colour setups. Each accepted word is traced by
// a local line model, and the expected pixels are checked against the output
// stream in order. Bursty sender, stalling receiver, two long output hold-offs.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_tb;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam logic [dlr_pkg::IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		dlr_pkg::req_type_t                req;
		logic [dlr_pkg::IN_TDATA_W-1:0]    data;
	} line_word_t;

	typedef struct packed {
		logic [dlr_pkg::PIX_W-1:0]   px;
		logic [dlr_pkg::PIX_W-1:0]   py;
		logic [dlr_pkg::ADDR_W-1:0]  addr;
		logic [dlr_pkg::COLOR_W-1:0] blue;
		logic [dlr_pkg::COLOR_W-1:0] green;
		logic [dlr_pkg::COLOR_W-1:0] red;
		logic                        outside;
		logic                        last;
	} pixel_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic [dlr_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
	logic [0:0]                       s_tuser = '0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [dlr_pkg::OUT_TDATA_W-1:0]  m_tdata;
	logic [0:0]                       m_tuser;
	logic                             m_tlast;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic                             cfg_wen = 1'b0;
	logic [dlr_pkg::IDX_W-1:0]        cfg_addr = '0;
	logic [dlr_pkg::CFG_W-1:0]        cfg_data = '0;

	dda_line_rasterizer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_wen  (cfg_wen),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #1 clk = ~clk;

	// stimulus and expected pixels
	line_word_t line_words[$];
	pixel_t     expected_pixels[$];
	int         words_queued = 0;
	int         words_taken = 0;
	int         bad_pixels = 0;
	int         pixels_seen = 0;

	// local copy of the frame setup
	logic [dlr_pkg::CFG_W-1:0]   cur_width = dlr_pkg::RST_FRAME_WIDTH;
	logic [dlr_pkg::CFG_W-1:0]   cur_height = dlr_pkg::RST_FRAME_HEIGHT;
	logic [dlr_pkg::COLOR_W-1:0] cur_red = dlr_pkg::RST_RED;
	logic [dlr_pkg::COLOR_W-1:0] cur_green = dlr_pkg::RST_GREEN;
	logic [dlr_pkg::COLOR_W-1:0] cur_blue = dlr_pkg::RST_BLUE;

	// local copy of the line being walked
	bit     ln_active = 0;
	bit     ln_ymaj = 0;
	bit     ln_neg = 0;
	int     ln_org_x = 0;
	int     ln_org_y = 0;
	int     ln_idx = 0;
	int     ln_end = 0;
	longint ln_slope = 0;
	longint ln_accum = 0;

	task automatic trace_word(input line_word_t w);
		int     sx, sy, dx, dy, lon, sho, nxt;
		longint alon, asho, q, off, px, py, wd, ht, addr;
		bit     fin, outside;
		pixel_t p;
		if (w.req == dlr_pkg::REQ_START) begin
			sx = $signed(w.data[15:0]);
			sy = $signed(w.data[31:16]);
			dx = int'($signed(w.data[47:32])) - sx;
			dy = int'($signed(w.data[63:48])) - sy;
			ln_ymaj = longint'(dy) * dy > longint'(dx) * dx;
			lon = ln_ymaj ? dy : dx;
			sho = ln_ymaj ? dx : dy;
			ln_org_x = sx;
			ln_org_y = sy;
			ln_end = lon;
			ln_idx = 0;
			ln_neg = lon < 0;
			ln_accum = 0;
			if (lon == 0) begin
				ln_active = 0;
				ln_slope = 0;
			end else begin
				alon = (lon < 0) ? -longint'(lon) : longint'(lon);
				asho = (sho < 0) ? -longint'(sho) : longint'(sho);
				q = (asho << dlr_pkg::FRAC_BITS) / alon;
				ln_slope = (sho < 0) ? -q : q;
				ln_active = 1;
			end
		end else if (ln_active) begin
			// minor offset truncates toward zero
			off = (ln_accum < 0) ? -((-ln_accum) >> dlr_pkg::FRAC_BITS) :
				(ln_accum >> dlr_pkg::FRAC_BITS);
			wd = (cur_width > dlr_pkg::MAX_WIDTH) ? dlr_pkg::MAX_WIDTH : longint'(cur_width);
			ht = (cur_height > dlr_pkg::MAX_WIDTH) ? dlr_pkg::MAX_WIDTH : longint'(cur_height);
			if (ln_ymaj) begin
				px = ln_org_x + off;
				py = longint'(ln_org_y) + ln_idx;
			end else begin
				px = longint'(ln_org_x) + ln_idx;
				py = ln_org_y + off;
			end
			outside = px < 0 || py < 0 || px >= wd || py >= ht;
			addr = outside ? 0 : (wd * py + px) * 3;
			nxt = ln_neg ? ln_idx - 1 : ln_idx + 1;
			fin = nxt == ln_end;
			ln_idx = nxt;
			ln_accum += ln_slope;
			if (fin) ln_active = 0;
			p.px = px[dlr_pkg::PIX_W-1:0];
			p.py = py[dlr_pkg::PIX_W-1:0];
			p.addr = addr[dlr_pkg::ADDR_W-1:0];
			p.blue = cur_blue;
			p.green = cur_green;
			p.red = cur_red;
			p.outside = outside;
			p.last = fin;
			expected_pixels.push_back(p);
		end
	endtask

	function automatic line_word_t start_word(int sx, int sy, int ex, int ey);
		line_word_t w;
		w.req = dlr_pkg::REQ_START;
		w.data = {16'(ey), 16'(ex), 16'(sy), 16'(sx)};
		return w;
	endfunction

	// step words ignore tdata; fill it anyway so every bit toggles
	function automatic line_word_t step_word();
		line_word_t w;
		w.req = dlr_pkg::REQ_STEP;
		w.data = {$urandom, $urandom};
		return w;
	endfunction

	task automatic push_word(input line_word_t w);
		line_words.push_back(w);
		words_queued++;
	endtask

	task automatic push_line(int sx, int sy, int ex, int ey, int steps);
		push_word(start_word(sx, sy, ex, ey));
		repeat (steps) push_word(step_word());
	endtask

	// all five registers plus one unmapped index, then the enable drops
	task automatic load_frame_setup(logic [dlr_pkg::CFG_W-1:0] w,
			logic [dlr_pkg::CFG_W-1:0] h, logic [dlr_pkg::CFG_W-1:0] r,
			logic [dlr_pkg::CFG_W-1:0] g, logic [dlr_pkg::CFG_W-1:0] b);
		logic [dlr_pkg::IDX_W-1:0] idx[6];
		logic [dlr_pkg::CFG_W-1:0] val[6];
		idx = '{dlr_pkg::REG_FRAME_WIDTH, dlr_pkg::REG_FRAME_HEIGHT, dlr_pkg::REG_DRAW_RED,
			dlr_pkg::REG_DRAW_GREEN, dlr_pkg::REG_DRAW_BLUE, REG_NONE};
		val = '{w, h, r, g, b, dlr_pkg::CFG_W'($urandom)};
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_wen <= 1'b1;
			cfg_addr <= idx[i];
			cfg_data <= val[i];
			case (idx[i])
				dlr_pkg::REG_FRAME_WIDTH:  cur_width = val[i];
				dlr_pkg::REG_FRAME_HEIGHT: cur_height = val[i];
				dlr_pkg::REG_DRAW_RED:     cur_red = val[i][dlr_pkg::COLOR_W-1:0];
				dlr_pkg::REG_DRAW_GREEN:   cur_green = val[i][dlr_pkg::COLOR_W-1:0];
				dlr_pkg::REG_DRAW_BLUE:    cur_blue = val[i][dlr_pkg::COLOR_W-1:0];
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic wait_drained();
		while (words_taken != words_queued || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// a coordinate around the frame so that lines cross its edges
	function automatic int near_coord(int dim);
		int d;
		d = (dim > dlr_pkg::MAX_WIDTH) ? dlr_pkg::MAX_WIDTH : dim;
		return int'($urandom_range(0, d + 16)) - 8;
	endfunction

	task automatic queue_random_lines(int n);
		int count, r, sx, sy, ex, ey, len, steps;
		count = 0;
		while (count < n) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				push_word(step_word());
			end else if (r < 12) begin
				sx = $signed(16'($urandom));
				sy = $signed(16'($urandom));
				push_line(sx, sy, sx, sy, 1);
				count += 1;
			end else if (r < 27) begin
				push_line($signed(16'($urandom)), $signed(16'($urandom)),
					$signed(16'($urandom)), $signed(16'($urandom)), 0);
				steps = $urandom_range(1, 12);
				repeat (steps) push_word(step_word());
				count += 1 + steps;
			end else begin
				sx = near_coord(int'(cur_width));
				sy = near_coord(int'(cur_height));
				ex = sx + int'($urandom_range(0, 48)) - 24;
				ey = sy + int'($urandom_range(0, 48)) - 24;
				len = (ex > sx) ? ex - sx : sx - ex;
				if (((ey > sy) ? ey - sy : sy - ey) > len)
					len = (ey > sy) ? ey - sy : sy - ey;
				r = $urandom_range(0, 99);
				if (len == 0) steps = 1;
				else if (r < 70) steps = len;
				else if (r < 85) steps = len + 1;
				else steps = $urandom_range(1, len);
				push_line(sx, sy, ex, ey, steps);
				count += 1 + steps;
			end
		end
	endtask

	// sender: bursts of words with gaps in between
	int         burst_left = 0;
	int         gap_left = 0;
	line_word_t cur_word;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				trace_word(cur_word);
				words_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0 || line_words.size() == 0) begin
					if (gap_left > 0) gap_left--;
					s_tvalid <= 1'b0;
				end else begin
					cur_word = line_words.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_word.data;
					s_tuser <= cur_word.req;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(0, 4) == 0) ?
							$urandom_range(40, 120) : $urandom_range(1, 16);
						gap_left = $urandom_range(1, 10);
					end
				end
			end
		end
	end

	// receiver: stall modes chosen at random, each held for a random span
	int     stall_mode = 0;
	int     mode_left = 0;
	int     hold_left = 0;
	int     rx_cycle = 0;
	pixel_t got_pixel;
	pixel_t want_pixel;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (m_tvalid && m_tready) begin
				got_pixel.px = m_tdata[16:0];
				got_pixel.py = m_tdata[33:17];
				got_pixel.addr = m_tdata[57:34];
				got_pixel.blue = m_tdata[65:58];
				got_pixel.green = m_tdata[73:66];
				got_pixel.red = m_tdata[81:74];
				got_pixel.outside = m_tuser[0];
				got_pixel.last = m_tlast;
				if (expected_pixels.size() == 0) begin
					bad_pixels++;
					$display("%0t: unexpected pixel x=%0d y=%0d, none expected",
						$time, $signed(got_pixel.px), $signed(got_pixel.py));
				end else begin
					want_pixel = expected_pixels.pop_front();
					if (got_pixel != want_pixel) begin
						bad_pixels++;
						$display({"%0t: pixel expected x=%0d y=%0d addr=%0d bgr=%h/%h/%h",
							" off=%b last=%b, actual x=%0d y=%0d addr=%0d bgr=%h/%h/%h",
							" off=%b last=%b"}, $time,
							$signed(want_pixel.px), $signed(want_pixel.py),
							want_pixel.addr, want_pixel.blue, want_pixel.green,
							want_pixel.red, want_pixel.outside, want_pixel.last,
							$signed(got_pixel.px), $signed(got_pixel.py),
							got_pixel.addr, got_pixel.blue, got_pixel.green,
							got_pixel.red, got_pixel.outside, got_pixel.last);
					end
				end
				pixels_seen++;
				// long hold-off so the pipeline backs up into the input
				if (pixels_seen == 100 || pixels_seen == 400) hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(8, 80);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (rx_cycle % 5) != 0;
				endcase
			end
		end
	end

	// watchdog: cycles with no handshake on either side and no config write
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("dda_line_rasterizer: mismatch");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset setup: 640x480, red
		push_word(step_word());                    // nothing armed yet
		push_line(0, 0, 0, 0, 1);                  // zero length
		push_line(0, 0, 4, 2, 5);                  // x major, one step past the end
		push_line(10, 10, 8, 14, 4);               // y major, minor going negative
		push_line(5, 5, 2, 8, 3);                  // tie goes to x, walking left
		push_line(-32768, -32768, 32767, 32767, 2);
		push_line(32767, -32768, -32768, 32767, 1);
		push_line(639, 479, 642, 479, 3);          // replaces the active line
		queue_random_lines(110);
		wait_drained();

		load_frame_setup(12'd1, 12'd1, 12'd0, 12'd0, 12'd0);
		queue_random_lines(130);
		wait_drained();

		// zero dimensions: everything off frame
		load_frame_setup(12'd0, 12'd0, 12'd255, 12'd255, 12'd255);
		queue_random_lines(120);
		wait_drained();

		// oversized dimensions saturate
		load_frame_setup(12'hfff, 12'hfff, 12'($urandom), 12'($urandom), 12'($urandom));
		queue_random_lines(130);
		wait_drained();

		load_frame_setup(12'd2048, 12'd2048, 12'($urandom), 12'($urandom), 12'($urandom));
		queue_random_lines(130);
		wait_drained();

		load_frame_setup(12'd5, 12'd3, 12'($urandom), 12'($urandom), 12'($urandom));
		queue_random_lines(130);
		wait_drained();

		load_frame_setup(12'($urandom_range(1, 2048)), 12'($urandom_range(1, 2048)),
			12'($urandom), 12'($urandom), 12'($urandom));
		queue_random_lines(130);
		wait_drained();

		load_frame_setup(dlr_pkg::RST_FRAME_WIDTH, dlr_pkg::RST_FRAME_HEIGHT, 12'($urandom),
			12'($urandom), 12'($urandom));
		queue_random_lines(130);
		wait_drained();

		if (bad_pixels == 0) begin
			$display("dda_line_rasterizer: match");
		end else begin
			$display("dda_line_rasterizer: mismatch");
		end
		$finish;
	end

endmodule
`default_nettype wire
